[hw/rtl/tsbb_pkg.sv]
// tensor shard byte bounds: shared types, constants and the format table
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tsbb_pkg;

    // field widths
    localparam int DIM_BITS  = 24;
    localparam int BYTE_BITS = 50;
    localparam int IDX_BITS  = 6;
    localparam int TOT_BITS  = 7;
    localparam int FMT_BITS  = 8;
    localparam int UB_BITS   = 9;
    localparam int SH_BITS   = 4;

    // configuration register indexes
    localparam logic CFG_NODE_INDEX = 1'b0;
    localparam logic CFG_NODE_TOTAL = 1'b1;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_FMT = 1'b1;

    // element format codes
    localparam logic [FMT_BITS-1:0] FMT_F32   = 8'd0;
    localparam logic [FMT_BITS-1:0] FMT_F16   = 8'd1;
    localparam logic [FMT_BITS-1:0] FMT_Q4_0  = 8'd2;
    localparam logic [FMT_BITS-1:0] FMT_Q4_1  = 8'd3;
    localparam logic [FMT_BITS-1:0] FMT_Q5_0  = 8'd6;
    localparam logic [FMT_BITS-1:0] FMT_Q5_1  = 8'd7;
    localparam logic [FMT_BITS-1:0] FMT_Q8_0  = 8'd8;
    localparam logic [FMT_BITS-1:0] FMT_Q8_1  = 8'd9;
    localparam logic [FMT_BITS-1:0] FMT_Q2_K  = 8'd11;
    localparam logic [FMT_BITS-1:0] FMT_Q3_K  = 8'd12;
    localparam logic [FMT_BITS-1:0] FMT_Q4_K  = 8'd13;
    localparam logic [FMT_BITS-1:0] FMT_Q8_K  = 8'd14;
    localparam logic [FMT_BITS-1:0] FMT_Q5_K  = 8'd16;
    localparam logic [FMT_BITS-1:0] FMT_Q6_K  = 8'd17;
    localparam logic [FMT_BITS-1:0] FMT_IQ_K  = 8'd18;
    localparam logic [FMT_BITS-1:0] FMT_I8    = 8'd24;
    localparam logic [FMT_BITS-1:0] FMT_I16   = 8'd25;
    localparam logic [FMT_BITS-1:0] FMT_I32   = 8'd26;

    // log2 of elements per unit
    localparam logic [SH_BITS-1:0] SH_SCALAR = 4'd0;
    localparam logic [SH_BITS-1:0] SH_BLK32  = 4'd5;
    localparam logic [SH_BITS-1:0] SH_BLK256 = 4'd8;

    typedef struct packed {
        logic [DIM_BITS-1:0] tensor_columns;
        logic [DIM_BITS-1:0] tensor_rows;
        logic [FMT_BITS-1:0] element_format;
        logic                split_by_columns;
    } t_in;

    typedef struct packed {
        logic [DIM_BITS-1:0]  shard_first_row;
        logic [DIM_BITS-1:0]  shard_rows;
        logic [DIM_BITS-1:0]  shard_cols;
        logic [BYTE_BITS-1:0] shard_byte_offset;
        logic [BYTE_BITS-1:0] shard_byte_length;
        logic                 status;
    } t_out;

    // decoded format
    typedef struct packed {
        logic               ok;
        logic [UB_BITS-1:0] unit_bytes;
        logic [SH_BITS-1:0] blk_shift;
    } t_fmt;

    // sideband carried alongside the divider
    typedef struct packed {
        t_fmt                fmt;
        logic                by_cols;
        logic [DIM_BITS-1:0] cols;
        logic [DIM_BITS-1:0] rows;
    } t_side;

    // share of one transaction, handed to the byte stages
    typedef struct packed {
        t_fmt                fmt;
        logic                by_cols;
        logic [DIM_BITS-1:0] first_row;
        logic [DIM_BITS-1:0] n_rows;
        logic [DIM_BITS-1:0] n_cols;
        logic [DIM_BITS-1:0] first_col;
    } t_share;

    function automatic t_fmt fmt_decode(input logic [FMT_BITS-1:0] code);
        t_fmt f;
        f.ok         = 1'b1;
        f.unit_bytes = 9'd0;
        f.blk_shift  = SH_BLK256;
        case (code)
            FMT_F32:  begin f.unit_bytes = 9'd4;   f.blk_shift = SH_SCALAR; end
            FMT_F16:  begin f.unit_bytes = 9'd2;   f.blk_shift = SH_SCALAR; end
            FMT_I8:   begin f.unit_bytes = 9'd1;   f.blk_shift = SH_SCALAR; end
            FMT_I16:  begin f.unit_bytes = 9'd2;   f.blk_shift = SH_SCALAR; end
            FMT_I32:  begin f.unit_bytes = 9'd4;   f.blk_shift = SH_SCALAR; end
            FMT_Q4_0: begin f.unit_bytes = 9'd18;  f.blk_shift = SH_BLK32;  end
            FMT_Q4_1: begin f.unit_bytes = 9'd20;  f.blk_shift = SH_BLK32;  end
            FMT_Q5_0: begin f.unit_bytes = 9'd22;  f.blk_shift = SH_BLK32;  end
            FMT_Q5_1: begin f.unit_bytes = 9'd24;  f.blk_shift = SH_BLK32;  end
            FMT_Q8_0: begin f.unit_bytes = 9'd34;  f.blk_shift = SH_BLK32;  end
            FMT_Q8_1: begin f.unit_bytes = 9'd36;  f.blk_shift = SH_BLK32;  end
            FMT_Q8_K: f.unit_bytes = 9'd256;
            FMT_Q2_K: f.unit_bytes = 9'd110;
            FMT_Q3_K: f.unit_bytes = 9'd138;
            FMT_Q4_K: f.unit_bytes = 9'd166;
            FMT_Q5_K: f.unit_bytes = 9'd144;
            FMT_Q6_K: f.unit_bytes = 9'd176;
            FMT_IQ_K: f.unit_bytes = 9'd210;
            default:  f.ok = 1'b0;
        endcase
        return f;
    endfunction

endpackage

[hw/rtl/tsbb_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on tsbb_pkg
`timescale 1ns / 1ps

module tsbb_div_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [tsbb_pkg::DIM_BITS-1:0] i_num,
    input  logic [tsbb_pkg::TOT_BITS-1:0] i_den,
    input  tsbb_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [tsbb_pkg::DIM_BITS-1:0] o_quo,
    output logic [tsbb_pkg::TOT_BITS-1:0] o_rem,
    output tsbb_pkg::t_side               o_side
);
    import tsbb_pkg::*;

    logic                r_vld  [DIM_BITS];
    logic [DIM_BITS-1:0] r_work [DIM_BITS];
    logic [TOT_BITS-1:0] r_rem  [DIM_BITS];
    t_side               r_side [DIM_BITS];

    genvar s;
    generate
        for (s = 0; s < DIM_BITS; s++) begin : g_stage
            logic                vld_in;
            logic [DIM_BITS-1:0] work_in;
            logic [TOT_BITS-1:0] rem_in;
            t_side               side_in;
            logic [TOT_BITS:0]   trial;
            logic                ge;
            logic [DIM_BITS-1:0] n_work;
            logic [TOT_BITS-1:0] n_rem;

            // stage input: ports for the first stage, previous register after
            if (s == 0) begin : g_first
                assign vld_in  = i_vld;
                assign work_in = i_num;
                assign rem_in  = '0;
                assign side_in = i_side;
            end else begin : g_next
                assign vld_in  = r_vld[s-1];
                assign work_in = r_work[s-1];
                assign rem_in  = r_rem[s-1];
                assign side_in = r_side[s-1];
            end

            // one trial subtract; quotient bit shifts in as dividend shifts out
            always_comb begin
                trial  = {rem_in, work_in[DIM_BITS-1]};
                ge     = (trial >= {1'b0, i_den});
                n_rem  = ge ? TOT_BITS'(trial - {1'b0, i_den}) : trial[TOT_BITS-1:0];
                n_work = {work_in[DIM_BITS-2:0], ge};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= vld_in;
                end
                r_work[s] <= n_work;
                r_rem[s]  <= n_rem;
                r_side[s] <= side_in;
            end
        end
    endgenerate

    assign o_vld  = r_vld[DIM_BITS-1];
    assign o_quo  = r_work[DIM_BITS-1];
    assign o_rem  = r_rem[DIM_BITS-1];
    assign o_side = r_side[DIM_BITS-1];

endmodule

[hw/rtl/tsbb_bytes.sv]
// byte offset and length of a share: unit count, then two multiply stages
// depends on tsbb_pkg
`timescale 1ns / 1ps

module tsbb_bytes (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  tsbb_pkg::t_share  i_share,
    output logic              o_vld,
    output tsbb_pkg::t_out    o_res
);
    import tsbb_pkg::*;

    localparam int PROD_BITS = 2 * DIM_BITS;
    localparam int FULL_BITS = PROD_BITS + UB_BITS;

    // stage 0 operands
    logic                r_m0_vld;
    t_share              r_m0_share;
    logic [DIM_BITS-1:0] r_m0_off_a, r_m0_off_b, r_m0_units;
    logic [DIM_BITS-1:0] n_off_a, n_off_b, n_units, blk_mask;

    // stage 1 and 2 products
    logic                 r_m1_vld;
    t_share               r_m1_share;
    logic [PROD_BITS-1:0] r_m1_off, r_m1_len;
    logic                 r_m2_vld;
    t_out                 r_m2_res;
    logic [FULL_BITS-1:0] off_full, len_full;

    // units in the share's part of a row, offset operands by split mode
    always_comb begin
        blk_mask = (DIM_BITS'(1) << i_share.fmt.blk_shift) - DIM_BITS'(1);
        n_units  = (i_share.n_cols >> i_share.fmt.blk_shift)
                 + DIM_BITS'(|(i_share.n_cols & blk_mask));
        if (i_share.by_cols) begin
            n_off_a = i_share.first_col >> i_share.fmt.blk_shift;
            n_off_b = DIM_BITS'(1);
        end else begin
            n_off_a = i_share.first_row;
            n_off_b = n_units;
        end
    end

    always_comb begin
        off_full = FULL_BITS'(r_m1_off) * FULL_BITS'(r_m1_share.fmt.unit_bytes);
        len_full = FULL_BITS'(r_m1_len) * FULL_BITS'(r_m1_share.fmt.unit_bytes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_vld <= 1'b0;
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
        end else begin
            r_m0_vld <= i_vld;
            r_m1_vld <= r_m0_vld;
            r_m2_vld <= r_m1_vld;
        end
        r_m0_share <= i_share;
        r_m0_off_a <= n_off_a;
        r_m0_off_b <= n_off_b;
        r_m0_units <= n_units;
        // units times rows, and the offset in units by split mode
        r_m1_share <= r_m0_share;
        r_m1_off   <= PROD_BITS'(r_m0_off_a) * PROD_BITS'(r_m0_off_b);
        r_m1_len   <= PROD_BITS'(r_m0_share.n_rows) * PROD_BITS'(r_m0_units);
        // scale by bytes per unit
        r_m2_res.shard_first_row   <= r_m1_share.first_row;
        r_m2_res.shard_rows        <= r_m1_share.n_rows;
        r_m2_res.shard_cols        <= r_m1_share.n_cols;
        r_m2_res.shard_byte_offset <= r_m1_share.fmt.ok ? off_full[BYTE_BITS-1:0] : '0;
        r_m2_res.shard_byte_length <= r_m1_share.fmt.ok ? len_full[BYTE_BITS-1:0] : '0;
        r_m2_res.status            <= r_m1_share.fmt.ok ? STATUS_OK : STATUS_BAD_FMT;
    end

    assign o_vld = r_m2_vld;
    assign o_res = r_m2_res;

endmodule

[hw/rtl/tensor_shard_byte_bounds.sv]
// tensor shard byte bounds top level: config registers, split and share stages
// depends on tsbb_pkg, tsbb_div_pipe, tsbb_bytes
`timescale 1ns / 1ps

// One tensor descriptor is taken per clock whenever busy is low, and its
// result appears on o_result with o_strobe high for exactly one cycle;
// results come out in order and cannot be held off. The path runs
// through an input register, the divider, which yields one quotient bit
// per pipeline stage, two share stages and three byte stages. busy is
// high during reset and is cleared once reset is released. Node index
// and node total may be written only while no descriptor is in flight.
module tensor_shard_byte_bounds (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tsbb_pkg::t_in                 i_item,
    output logic                          o_strobe,
    output tsbb_pkg::t_out                o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [tsbb_pkg::TOT_BITS-1:0] i_cfg_data
);
    import tsbb_pkg::*;

    localparam int LATENCY = DIM_BITS + 6;
    localparam int SUM_BITS = DIM_BITS + IDX_BITS + 1;

    logic                r_busy;
    logic [IDX_BITS-1:0] r_node_index;
    logic [TOT_BITS-1:0] r_node_total;
    logic [TOT_BITS-1:0] tot_eff;
    logic                accept;

    // input stage
    logic                r_s0_vld;
    t_side               r_s0_side;
    logic [DIM_BITS-1:0] r_s0_num;

    // divider outputs
    logic                d_vld;
    logic [DIM_BITS-1:0] d_quo;
    logic [TOT_BITS-1:0] d_rem;
    t_side               d_side;

    // share stage a
    logic                       r_a_vld;
    t_side                      r_a_side;
    logic [DIM_BITS+IDX_BITS-1:0] r_a_prod;
    logic [DIM_BITS-1:0]        r_a_per;
    logic [TOT_BITS-1:0]        r_a_min;
    logic                       r_a_lt, r_a_empty;

    // share stage b
    logic                r_b_vld;
    t_share              r_b_share;
    t_share              n_share;
    logic [DIM_BITS-1:0] n_start, n_count, n_total_dim;
    logic [SUM_BITS-1:0] start_sum;

    assign accept      = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;
    assign tot_eff     = (r_node_total == '0) ? TOT_BITS'(1) : r_node_total;

    // configuration write transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_node_index <= '0;
            r_node_total <= TOT_BITS'(1);
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NODE_INDEX: r_node_index <= i_cfg_data[IDX_BITS-1:0];
                    CFG_NODE_TOTAL: r_node_total <= i_cfg_data;
                    default:        r_node_total <= r_node_total;
                endcase
            end
        end
    end

    // register the descriptor, decode its format and pick the split dimension
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= accept;
        end
        r_s0_side.fmt     <= fmt_decode(i_item.element_format);
        r_s0_side.by_cols <= i_item.split_by_columns;
        r_s0_side.cols    <= i_item.tensor_columns;
        r_s0_side.rows    <= i_item.tensor_rows;
        r_s0_num          <= i_item.split_by_columns ? i_item.tensor_columns
                                                     : i_item.tensor_rows;
    end

    tsbb_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s0_vld),
        .i_num   (r_s0_num),
        .i_den   (tot_eff),
        .i_side  (r_s0_side),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_rem   (d_rem),
        .o_side  (d_side)
    );

    // index times share size, and the extra-one terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= d_vld;
        end
        r_a_side  <= d_side;
        r_a_prod  <= (DIM_BITS+IDX_BITS)'(r_node_index) * (DIM_BITS+IDX_BITS)'(d_quo);
        r_a_per   <= d_quo;
        r_a_lt    <= (TOT_BITS'(r_node_index) < d_rem);
        r_a_min   <= (TOT_BITS'(r_node_index) < d_rem) ? TOT_BITS'(r_node_index) : d_rem;
        r_a_empty <= (TOT_BITS'(r_node_index) >= tot_eff);
    end

    // first element and count of the share, then fields by split mode
    always_comb begin
        n_total_dim = r_a_side.by_cols ? r_a_side.cols : r_a_side.rows;
        start_sum   = SUM_BITS'(r_a_prod) + SUM_BITS'(r_a_min);
        if (r_a_empty) begin
            n_start = n_total_dim;
            n_count = '0;
        end else begin
            n_start = start_sum[DIM_BITS-1:0];
            n_count = r_a_per + DIM_BITS'(r_a_lt);
        end
        n_share.fmt     = r_a_side.fmt;
        n_share.by_cols = r_a_side.by_cols;
        if (r_a_side.by_cols) begin
            n_share.first_row = '0;
            n_share.n_rows    = r_a_side.rows;
            n_share.n_cols    = n_count;
            n_share.first_col = n_start;
        end else begin
            n_share.first_row = n_start;
            n_share.n_rows    = n_count;
            n_share.n_cols    = r_a_side.cols;
            n_share.first_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_share <= n_share;
    end

    tsbb_bytes u_bytes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_share (r_b_share),
        .o_vld   (o_strobe),
        .o_res   (o_result)
    );

    // every accepted transaction gives one strobe after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("result strobe missing after accepted transaction");

    // no strobe without a transaction accepted at the fixed latency before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result strobe without accepted transaction");

    // a bad format carries no bytes
    a_bad_fmt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == STATUS_BAD_FMT) |->
        (o_result.shard_byte_offset == '0 && o_result.shard_byte_length == '0))
        else $error("unsupported format with nonzero byte range");

    // a node outside the split gets an empty share
    a_empty_share: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && TOT_BITS'(r_node_index) >= tot_eff) |->
        (o_result.shard_byte_length == '0
         && (o_result.shard_rows == '0 || o_result.shard_cols == '0)))
        else $error("node outside split has nonempty share");

endmodule
